[hdl/tbi_pkg.sv]
package tbi_pkg;

  // Q16.16 samples and coordinates
  localparam int FracBits = 16;
  localparam int FracW    = FracBits + 1;
  localparam logic [FracW-1:0] FracOne = FracW'(1) << FracBits;

  localparam int DataW  = 32;
  localparam int DiffW  = DataW + 1;
  localparam int ProdW  = 2 * DataW;
  localparam int IntLsb = 2 * FracBits;
  localparam int IntW   = ProdW - IntLsb;

  // 64 x 64 grid split into four banks by row and column parity
  localparam int IdxW      = 6;
  localparam int BankAddrW = 2 * (IdxW - 1);
  localparam int BankDepth = 1 << BankAddrW;
  localparam int NumBanks  = 4;
  localparam int BankSelW  = 2;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  localparam int CfgIdxW = 3;
  localparam int SDataW  = 112;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERP_MODE = 3'd0,
    CFG_X_DIV_COUNT = 3'd1,
    CFG_Y_DIV_COUNT = 3'd2,
    CFG_X_ORIGIN    = 3'd3,
    CFG_Y_ORIGIN    = 3'd4,
    CFG_X_INV_STEP  = 3'd5,
    CFG_Y_INV_STEP  = 3'd6,
    CFG_FIXED_VALUE = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_NEAREST = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_FIXED   = 2'd2,
    MODE_UNUSED  = 2'd3
  } interp_mode_e;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_NEAR  = 3'd1,
    OP_LIN2D = 3'd2,
    OP_LIN1D = 3'd3,
    OP_FIXED = 3'd4,
    OP_ZERO  = 3'd5
  } op_e;

  typedef struct packed {
    interp_mode_e            mode;
    logic [IdxW-1:0]         x_divs;
    logic [IdxW-1:0]         y_divs;
    logic signed [DataW-1:0] x_origin;
    logic signed [DataW-1:0] y_origin;
    logic signed [DataW-1:0] x_inv;
    logic signed [DataW-1:0] y_inv;
    logic signed [DataW-1:0] fixed_value;
  } cfg_t;

  // row/col are the write address or the lower corner of a lookup
  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [FracW-1:0] frac_x;
    logic [FracW-1:0] frac_y;
    logic [DataW-1:0] wdata;
  } item_t;

endpackage

[hdl/tbi_ram.sv]
module tbi_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tbi_front.sv]
module tbi_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tbi_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_func_i,
  input  logic [tbi_pkg::IdxW-1:0]          in_row_i,
  input  logic [tbi_pkg::IdxW-1:0]          in_col_i,
  input  logic signed [tbi_pkg::DataW-1:0]  in_value_i,
  input  logic signed [tbi_pkg::DataW-1:0]  in_x_i,
  input  logic signed [tbi_pkg::DataW-1:0]  in_y_i,
  output logic                              item_valid_o,
  input  logic                              item_ready_i,
  output tbi_pkg::item_t                    item_o
);

  typedef struct packed {
    logic [tbi_pkg::IdxW-1:0]  idx;
    logic [tbi_pkg::FracW-1:0] frac;
  } lin_t;

  function automatic logic [tbi_pkg::IdxW-1:0] near_idx(
    input logic signed [tbi_pkg::ProdW-1:0] s,
    input logic [tbi_pkg::IdxW-1:0]         divs
  );
    logic [tbi_pkg::IntW-1:0] ip;
    ip = s[tbi_pkg::ProdW-1:tbi_pkg::IntLsb];
    if (s[tbi_pkg::ProdW-1]) begin
      return '0;
    end else if (ip > tbi_pkg::IntW'(divs)) begin
      return divs;
    end
    return s[tbi_pkg::IntLsb +: tbi_pkg::IdxW];
  endfunction

  function automatic lin_t lin_idx(
    input logic signed [tbi_pkg::ProdW-1:0] s,
    input logic [tbi_pkg::IdxW-1:0]         divs
  );
    logic [tbi_pkg::IntW-1:0] ip;
    lin_t                     r;
    ip = s[tbi_pkg::ProdW-1:tbi_pkg::IntLsb];
    if (s[tbi_pkg::ProdW-1]) begin
      r.idx  = '0;
      r.frac = '0;
    end else if (ip >= tbi_pkg::IntW'(divs)) begin
      // at or past the far edge: last cell, full fraction
      r.idx  = divs - tbi_pkg::IdxW'(1);
      r.frac = tbi_pkg::FracOne;
    end else begin
      r.idx  = s[tbi_pkg::IntLsb +: tbi_pkg::IdxW];
      r.frac = {1'b0, s[tbi_pkg::FracBits +: tbi_pkg::FracBits]};
    end
    return r;
  endfunction

  logic                               advance;
  logic                               f1_valid_d, f1_valid_q, f2_valid_q;
  logic                               f1_func_q, f2_func_q;
  logic [tbi_pkg::IdxW-1:0]           f1_row_q, f1_col_q, f2_row_q, f2_col_q;
  logic [tbi_pkg::DataW-1:0]          f1_value_q, f2_value_q;
  logic signed [tbi_pkg::DiffW-1:0]   dx_d, dy_d, f1_dx_q, f1_dy_q;
  logic signed [tbi_pkg::DiffW+tbi_pkg::DataW-1:0] prod_x, prod_y;
  logic signed [tbi_pkg::ProdW-1:0]   f2_sx_q, f2_sy_q;
  logic [tbi_pkg::IdxW-1:0]           y_divs;
  lin_t                               lx, ly;
  tbi_pkg::item_t                     item_d;

  assign advance    = !f2_valid_q || item_ready_i;
  assign in_ready_o = advance;
  assign f1_valid_d = in_valid_i;

  assign dx_d = tbi_pkg::DiffW'(in_x_i) - tbi_pkg::DiffW'(cfg_i.x_origin);
  assign dy_d = tbi_pkg::DiffW'(in_y_i) - tbi_pkg::DiffW'(cfg_i.y_origin);

  assign prod_x = f1_dx_q * cfg_i.x_inv;
  assign prod_y = f1_dy_q * cfg_i.y_inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (advance) begin
      f1_valid_q <= f1_valid_d;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      f1_func_q  <= in_func_i;
      f1_row_q   <= in_row_i;
      f1_col_q   <= in_col_i;
      f1_value_q <= in_value_i;
      f1_dx_q    <= dx_d;
      f1_dy_q    <= dy_d;
      f2_func_q  <= f1_func_q;
      f2_row_q   <= f1_row_q;
      f2_col_q   <= f1_col_q;
      f2_value_q <= f1_value_q;
      f2_sx_q    <= prod_x[tbi_pkg::ProdW-1:0];
      f2_sy_q    <= prod_y[tbi_pkg::ProdW-1:0];
    end
  end

  // zero y divisions behave as one
  assign y_divs = (cfg_i.y_divs == '0) ? tbi_pkg::IdxW'(1) : cfg_i.y_divs;
  assign lx     = lin_idx(f2_sx_q, cfg_i.x_divs);
  assign ly     = lin_idx(f2_sy_q, y_divs);

  always_comb begin
    item_d        = '0;
    item_d.op     = tbi_pkg::OP_WRITE;
    item_d.row    = f2_row_q;
    item_d.col    = f2_col_q;
    item_d.wdata  = f2_value_q;
    if (f2_func_q) begin
      item_d.wdata = '0;
      unique case (cfg_i.mode)
        tbi_pkg::MODE_NEAREST: begin
          item_d.op  = tbi_pkg::OP_NEAR;
          item_d.row = (cfg_i.x_divs != '0) ? near_idx(f2_sx_q, cfg_i.x_divs) : '0;
          item_d.col = near_idx(f2_sy_q, y_divs);
        end
        tbi_pkg::MODE_LINEAR: begin
          item_d.col    = ly.idx;
          item_d.frac_y = ly.frac;
          if (cfg_i.x_divs != '0) begin
            item_d.op     = tbi_pkg::OP_LIN2D;
            item_d.row    = lx.idx;
            item_d.frac_x = lx.frac;
          end else begin
            item_d.op     = tbi_pkg::OP_LIN1D;
            item_d.row    = '0;
            item_d.frac_x = '0;
          end
        end
        tbi_pkg::MODE_FIXED: begin
          item_d.op = tbi_pkg::OP_FIXED;
        end
        tbi_pkg::MODE_UNUSED: begin
          item_d.op = tbi_pkg::OP_ZERO;
        end
      endcase
    end
  end

  assign item_valid_o = f2_valid_q;
  assign item_o       = item_d;

endmodule

[hdl/tbi_queue.sv]
module tbi_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbi_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tbi_pkg::item_t item_o
);

  tbi_pkg::item_t                  mem_q [tbi_pkg::QueueDepth];
  logic [tbi_pkg::QueuePtrW-1:0]   wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [tbi_pkg::QueueCntW-1:0]   count_d, count_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + tbi_pkg::QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + tbi_pkg::QueuePtrW'(1) : rd_ptr_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + tbi_pkg::QueueCntW'(1);
      2'b01:   count_d = count_q - tbi_pkg::QueueCntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o  = (count_q == tbi_pkg::QueueCntW'(tbi_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

endmodule

[hdl/tbi_back.sv]
module tbi_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tbi_pkg::cfg_t                    cfg_i,
  input  logic                             item_valid_i,
  input  tbi_pkg::item_t                   item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [tbi_pkg::DataW-1:0] out_value_o
);

  localparam int LerpW = tbi_pkg::DiffW + tbi_pkg::FracW + 1;

  logic                                  advance, is_write;
  logic [tbi_pkg::BankAddrW-1:0]         bank_addr [tbi_pkg::NumBanks];
  logic [tbi_pkg::DataW-1:0]             bank_rdata [tbi_pkg::NumBanks];

  logic                                  b1_valid_q, b2_valid_q, b3_valid_q;
  logic                                  b4_valid_q, b5_valid_q, b6_valid_q;
  logic                                  out_valid_q;
  tbi_pkg::op_e                          b1_op_q, b2_op_q, b3_op_q, b4_op_q, b5_op_q, b6_op_q;
  logic                                  b1_rp_q, b1_cp_q;
  logic [tbi_pkg::FracW-1:0]             b1_fx_q, b1_fy_q, b2_fx_q, b2_fy_q;
  logic [tbi_pkg::FracW-1:0]             b3_fy_q, b4_fy_q, b5_fy_q;

  logic signed [tbi_pkg::DataW-1:0]      ca, cb, cc, cd;
  logic signed [tbi_pkg::DataW-1:0]      b2_a_q, b2_c_q, b3_a_q, b3_c_q;
  logic signed [tbi_pkg::DiffW-1:0]      b2_dab_q, b2_dcd_q;
  logic signed [LerpW-1:0]               pab_d, pcd_d, b3_pab_q, b3_pcd_q;
  logic signed [LerpW-1:0]               lo_w, hi_w;
  logic signed [tbi_pkg::DataW-1:0]      b4_lo_q, b4_hi_q, b5_lo_q, b6_lo_q;
  logic signed [tbi_pkg::DiffW-1:0]      b5_dlh_q;
  logic signed [LerpW-1:0]               plh_d, b6_plh_q, r_w;
  logic signed [tbi_pkg::DataW-1:0]      out_d, out_value_q;

  assign advance  = !out_valid_q || out_ready_i;
  assign pop_o    = item_valid_i && advance;
  assign is_write = (item_i.op == tbi_pkg::OP_WRITE);

  // Each bank holds one parity class, so the four corners land in four banks
  for (genvar b = 0; b < tbi_pkg::NumBanks; b++) begin : g_bank
    localparam logic RowPar = 1'((b >> 1) & 1);
    localparam logic ColPar = 1'(b & 1);
    logic [tbi_pkg::IdxW:0] row_use, col_use;
    logic                   we;

    assign row_use = (item_i.row[0] == RowPar) ? {1'b0, item_i.row}
                                               : {1'b0, item_i.row} + (tbi_pkg::IdxW+1)'(1);
    assign col_use = (item_i.col[0] == ColPar) ? {1'b0, item_i.col}
                                               : {1'b0, item_i.col} + (tbi_pkg::IdxW+1)'(1);
    assign bank_addr[b] = {row_use[tbi_pkg::IdxW-1:1], col_use[tbi_pkg::IdxW-1:1]};
    assign we = pop_o && is_write && (item_i.row[0] == RowPar) && (item_i.col[0] == ColPar);

    tbi_ram #(
      .Width(tbi_pkg::DataW),
      .Depth(tbi_pkg::BankDepth)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(bank_addr[b]),
      .wdata_i(item_i.wdata),
      .re_i   (advance),
      .raddr_i(bank_addr[b]),
      .rdata_o(bank_rdata[b])
    );
  end

  // Pick corners out of the banks; collapse unused ones onto used ones
  always_comb begin
    ca = bank_rdata[{b1_rp_q, b1_cp_q}];
    cb = bank_rdata[{!b1_rp_q, b1_cp_q}];
    cc = bank_rdata[{b1_rp_q, !b1_cp_q}];
    cd = bank_rdata[{!b1_rp_q, !b1_cp_q}];
    priority case (b1_op_q)
      tbi_pkg::OP_NEAR: begin
        cb = ca;
        cc = ca;
        cd = ca;
      end
      tbi_pkg::OP_LIN1D: begin
        cb = ca;
        cd = cc;
      end
      default: ;
    endcase
  end

  assign pab_d = b2_dab_q * $signed({1'b0, b2_fx_q});
  assign pcd_d = b2_dcd_q * $signed({1'b0, b2_fx_q});
  assign lo_w  = b3_a_q + (b3_pab_q >>> tbi_pkg::FracBits);
  assign hi_w  = b3_c_q + (b3_pcd_q >>> tbi_pkg::FracBits);
  assign plh_d = b5_dlh_q * $signed({1'b0, b5_fy_q});
  assign r_w   = b6_lo_q + (b6_plh_q >>> tbi_pkg::FracBits);

  always_comb begin
    unique case (b6_op_q)
      tbi_pkg::OP_NEAR,
      tbi_pkg::OP_LIN2D,
      tbi_pkg::OP_LIN1D: out_d = r_w[tbi_pkg::DataW-1:0];
      tbi_pkg::OP_FIXED: out_d = cfg_i.fixed_value;
      default:           out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      b4_valid_q  <= 1'b0;
      b5_valid_q  <= 1'b0;
      b6_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      // writes end here; only lookups travel on
      b1_valid_q  <= pop_o && !is_write;
      b2_valid_q  <= b1_valid_q;
      b3_valid_q  <= b2_valid_q;
      b4_valid_q  <= b3_valid_q;
      b5_valid_q  <= b4_valid_q;
      b6_valid_q  <= b5_valid_q;
      out_valid_q <= b6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b1_op_q     <= item_i.op;
      b1_rp_q     <= item_i.row[0];
      b1_cp_q     <= item_i.col[0];
      b1_fx_q     <= item_i.frac_x;
      b1_fy_q     <= item_i.frac_y;

      b2_op_q     <= b1_op_q;
      b2_fx_q     <= b1_fx_q;
      b2_fy_q     <= b1_fy_q;
      b2_a_q      <= ca;
      b2_c_q      <= cc;
      b2_dab_q    <= tbi_pkg::DiffW'(cb) - tbi_pkg::DiffW'(ca);
      b2_dcd_q    <= tbi_pkg::DiffW'(cd) - tbi_pkg::DiffW'(cc);

      b3_op_q     <= b2_op_q;
      b3_fy_q     <= b2_fy_q;
      b3_a_q      <= b2_a_q;
      b3_c_q      <= b2_c_q;
      b3_pab_q    <= pab_d;
      b3_pcd_q    <= pcd_d;

      b4_op_q     <= b3_op_q;
      b4_fy_q     <= b3_fy_q;
      b4_lo_q     <= lo_w[tbi_pkg::DataW-1:0];
      b4_hi_q     <= hi_w[tbi_pkg::DataW-1:0];

      b5_op_q     <= b4_op_q;
      b5_fy_q     <= b4_fy_q;
      b5_lo_q     <= b4_lo_q;
      b5_dlh_q    <= tbi_pkg::DiffW'(b4_hi_q) - tbi_pkg::DiffW'(b4_lo_q);

      b6_op_q     <= b5_op_q;
      b6_lo_q     <= b5_lo_q;
      b6_plh_q    <= plh_d;

      out_value_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;

endmodule

[hdl/table_bilinear_interpolator_top.sv]
// Bilinear lookup table over a 64 x 64 grid of Q16.16 samples. Each request on the
// slave stream either stores one grid entry (tuser 0) or looks up a value (tuser 1);
// a lookup gives one result on the master stream, a store gives none, and results keep
// request order. One request is taken per clock unless a full queue stalls it; a lookup
// is registered through the front end, the queue and the blend pipeline, and writes are
// seen by every later lookup. The rate comes from the grid being split into four banks
// by row and column parity, each with its own read port, so all four corners are
// read in one cycle. A four-entry queue between the coordinate front end and the blend
// pipeline keeps requests flowing while the output waits. The user must write
// configuration registers only while no request is in flight; the block does not
// enforce this. A lookup touching an entry never written gives an undefined result.
module table_bilinear_interpolator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // row_index[5:0], col_index[11:6], entry_value[43:12], x_pos[75:44], y_pos[107:76]
  input  logic [tbi_pkg::SDataW-1:0]          s_axis_tdata,
  // func: 0 write entry, 1 lookup
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_value[31:0]
  output logic [tbi_pkg::DataW-1:0]           m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tbi_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [tbi_pkg::DataW-1:0]           cfg_data_i
);

  tbi_pkg::cfg_t   cfg_q;
  tbi_pkg::item_t  front_item, queue_item;
  logic            front_valid, queue_full, queue_valid, queue_pop;
  logic            cfg_we;
  logic signed [tbi_pkg::DataW-1:0] result;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= tbi_pkg::MODE_LINEAR;
      cfg_q.x_divs      <= '0;
      cfg_q.y_divs      <= tbi_pkg::IdxW'(1);
      cfg_q.x_origin    <= '0;
      cfg_q.y_origin    <= '0;
      cfg_q.x_inv       <= tbi_pkg::DataW'(1) << tbi_pkg::FracBits;
      cfg_q.y_inv       <= tbi_pkg::DataW'(1) << tbi_pkg::FracBits;
      cfg_q.fixed_value <= '0;
    end else if (cfg_we) begin
      unique case (tbi_pkg::cfg_reg_e'(cfg_index_i))
        tbi_pkg::CFG_INTERP_MODE: cfg_q.mode        <= tbi_pkg::interp_mode_e'(cfg_data_i[1:0]);
        tbi_pkg::CFG_X_DIV_COUNT: cfg_q.x_divs      <= cfg_data_i[tbi_pkg::IdxW-1:0];
        tbi_pkg::CFG_Y_DIV_COUNT: cfg_q.y_divs      <= cfg_data_i[tbi_pkg::IdxW-1:0];
        tbi_pkg::CFG_X_ORIGIN:    cfg_q.x_origin    <= cfg_data_i;
        tbi_pkg::CFG_Y_ORIGIN:    cfg_q.y_origin    <= cfg_data_i;
        tbi_pkg::CFG_X_INV_STEP:  cfg_q.x_inv       <= cfg_data_i;
        tbi_pkg::CFG_Y_INV_STEP:  cfg_q.y_inv       <= cfg_data_i;
        tbi_pkg::CFG_FIXED_VALUE: cfg_q.fixed_value <= cfg_data_i;
      endcase
    end
  end

  tbi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser),
    .in_row_i    (s_axis_tdata[5:0]),
    .in_col_i    (s_axis_tdata[11:6]),
    .in_value_i  (s_axis_tdata[43:12]),
    .in_x_i      (s_axis_tdata[75:44]),
    .in_y_i      (s_axis_tdata[107:76]),
    .item_valid_o(front_valid),
    .item_ready_i(!queue_full),
    .item_o      (front_item)
  );

  tbi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid && !queue_full),
    .item_i (front_item),
    .full_o (queue_full),
    .pop_i  (queue_pop),
    .valid_o(queue_valid),
    .item_o (queue_item)
  );

  tbi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(queue_valid),
    .item_i      (queue_item),
    .pop_o       (queue_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (result)
  );

  assign m_axis_tdata = result;

endmodule

[hdl/tbi_checker.sv]
module tbi_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [tbi_pkg::DataW-1:0]  m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // reset empties the output stage at once
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // no result can show until a request has passed the whole pipeline after reset
  assert property (@(posedge clk_i) $past(!rst_ni, 4) |-> !m_axis_tvalid)
    else $error("result appeared too soon after reset");

endmodule

bind table_bilinear_interpolator_top tbi_checker u_tbi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
